// ===== sv/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/sbt_pkg.sv =====
// Package with types, constants and helper functions of the source byte tokenizer.
`timescale 1ns / 1ps

package sbt_pkg;

    localparam int MAX_WORD_BYTES = 32;
    localparam int IDX_W          = $clog2(MAX_WORD_BYTES);
    localparam int LEN_W          = $clog2(MAX_WORD_BYTES + 1);
    localparam int KW_COUNT       = 7;

    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_DIGIT_0 = 8'd48;
    localparam logic [7:0] CH_DIGIT_9 = 8'd57;
    localparam logic [7:0] CH_HASH    = "#";
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_AT      = "@";
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LPAREN  = "(";
    localparam logic [7:0] CH_RPAREN  = ")";
    localparam logic [7:0] CH_LBRACE  = "{";
    localparam logic [7:0] CH_RBRACE  = "}";
    localparam logic [7:0] CH_SEMI    = ";";
    localparam logic [7:0] CH_COLON   = ":";
    localparam logic [7:0] CH_EQUAL   = "=";
    localparam logic [7:0] CH_LESS    = "<";
    localparam logic [7:0] CH_GREATER = ">";
    localparam logic [7:0] CH_BANG    = "!";

    localparam logic [4:0] KIND_IDENT   = 5'd7;
    localparam logic [4:0] KIND_NUMBER  = 5'd8;
    localparam logic [4:0] KIND_LPAREN  = 5'd9;
    localparam logic [4:0] KIND_RPAREN  = 5'd10;
    localparam logic [4:0] KIND_LBRACE  = 5'd11;
    localparam logic [4:0] KIND_RBRACE  = 5'd12;
    localparam logic [4:0] KIND_SEMI    = 5'd13;
    localparam logic [4:0] KIND_COLON   = 5'd14;
    localparam logic [4:0] KIND_STRING  = 5'd15;
    localparam logic [4:0] KIND_ATTR    = 5'd16;
    localparam logic [4:0] KIND_OP_BASE = 5'd17;
    localparam logic [4:0] KIND_ERROR   = 5'd25;

    localparam logic [1:0] OP_ASSIGN  = 2'd0;
    localparam logic [1:0] OP_LESS    = 2'd1;
    localparam logic [1:0] OP_GREATER = 2'd2;
    localparam logic [1:0] OP_BANG    = 2'd3;

    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd6, 3'd2, 3'd4, 3'd4, 3'd3, 3'd5};

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WORD = 3'd1,
        MODE_NUM  = 3'd2,
        MODE_STR  = 3'd3,
        MODE_ATTR = 3'd4,
        MODE_CMT  = 3'd5,
        MODE_OP   = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND,
        ST_SINGLE,
        ST_TAIL
    } state_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } src_item_t;

    typedef struct packed {
        logic [4:0] token_kind;
        logic [7:0] text_byte;
        logic       has_text;
        logic       text_truncated;
        logic       token_done;
        logic       last;
    } tok_item_t;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= CH_LOWER_A) && (c <= CH_LOWER_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    // Keywords that still agree with a word after byte c lands at position pos.
    function automatic logic [KW_COUNT-1:0] kw_step(input logic [LEN_W-1:0] pos,
                                                    input logic [7:0] c);
        logic [KW_COUNT-1:0] m;
        m = '0;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (pos < LEN_W'(KW_LEN[k]))
            begin
                m[k] = (KW_TEXT[k][pos[2:0]] == c);
            end
        end
        return m;
    endfunction

endpackage

// ===== sv/source_byte_tokenizer_unit.sv =====
// Top level of the source byte tokenizer: scanner, word memory and result sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The tokenizer takes one source byte per transaction and returns tokens, one
// result per text byte. A byte that only extends a word, number, string or
// attribute, or that is skipped, is taken while the unit stays idle. Text is
// kept in a synchronous word memory of MAX_WORD_BYTES entries; each text byte
// of a finished token is read from the memory in ST_READ and loaded into the
// output register in ST_SEND, which waits for a free output slot. Keywords,
// operators, punctuation and error tokens give one result each. Keyword
// matching is done byte by byte as the word is written, so no extra pass over
// the memory is needed. The next byte is taken once the last result of the
// current one sits in the output register.
module source_byte_tokenizer_unit
    import sbt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  src_item_t src_data,
    output logic      tok_valid,
    input  logic      tok_ready,
    output tok_item_t tok_data
);

    logic [7:0] mem [MAX_WORD_BYTES];
    logic [7:0] mem_rdata_reg;
    logic       mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0] mem_wdata;
    logic       mem_re;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    logic [1:0] pend_reg, pend_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic ovf_reg, ovf_next;
    logic [KW_COUNT-1:0] mask_reg, mask_next;

    logic fl_text_reg, fl_text_next;
    logic fl_single_reg, fl_single_next;
    logic [4:0] fl_kind_reg, fl_kind_next;
    logic fl_trunc_reg, fl_trunc_next;
    logic [LEN_W-1:0] flen_reg;
    logic tail_en_reg, tail_en_next;
    logic [4:0] tail_kind_reg, tail_kind_next;
    logic [7:0] tail_byte_reg, tail_byte_next;
    logic tail_has_reg, tail_has_next;
    logic dw_en_reg, dw_en_next;
    logic [7:0] dw_byte_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic out_valid_reg, out_valid_next;
    tok_item_t out_reg, out_next;
    logic load;
    logic slot_free;
    logic is_end;

    logic accept;
    logic [7:0] c;
    logic flush_en, do_idle, append_en, append_fits;
    logic [LEN_W-1:0] app_pos;
    logic kw_hit;
    logic [4:0] kw_kind;
    logic text_mode;
    logic acc_we;

    assign accept    = src_valid && src_ready;
    assign c         = src_data.data_byte;
    assign slot_free = !out_valid_reg || tok_ready;
    assign is_end    = (LEN_W'(idx_reg) + LEN_W'(1)) == flen_reg;
    assign tok_valid = out_valid_reg;
    assign tok_data  = out_reg;

    always_comb
    begin
        kw_hit  = 1'b0;
        kw_kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (!ovf_reg && mask_reg[k] && (len_reg == LEN_W'(KW_LEN[k])))
            begin
                kw_hit  = 1'b1;
                kw_kind = 5'(k);
            end
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        pend_next      = pend_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        mask_next      = mask_reg;
        flush_en       = 1'b0;
        do_idle        = 1'b0;
        append_en      = 1'b0;
        tail_en_next   = 1'b0;
        tail_kind_next = KIND_ERROR;
        tail_byte_next = '0;
        tail_has_next  = 1'b0;
        app_pos        = '0;
        append_fits    = 1'b0;

        if (src_data.end_of_stream)
        begin
            flush_en = 1'b1;
        end
        else
        begin
            case (mode_reg) inside
                MODE_WORD, MODE_ATTR:
                begin
                    if (is_lower(c))
                        append_en = 1'b1;
                    else
                    begin
                        flush_en = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                MODE_NUM:
                begin
                    if (is_digit(c))
                        append_en = 1'b1;
                    else
                    begin
                        flush_en = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    if (c == CH_QUOTE)
                        flush_en = 1'b1;
                    else
                        append_en = 1'b1;
                end
                MODE_CMT:
                begin
                    if (c == CH_NEWLINE)
                        mode_next = MODE_IDLE;
                end
                MODE_OP:
                begin
                    if (c == CH_EQUAL)
                    begin
                        tail_en_next   = 1'b1;
                        tail_kind_next = KIND_OP_BASE + {2'b00, pend_reg, 1'b1};
                        mode_next      = MODE_IDLE;
                    end
                    else
                    begin
                        flush_en = 1'b1;
                        do_idle  = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    do_idle   = 1'b1;
                end
            endcase
        end

        if (flush_en || do_idle)
        begin
            if (flush_en)
                mode_next = MODE_IDLE;
            len_next  = '0;
            ovf_next  = 1'b0;
            mask_next = '1;
        end

        if (do_idle)
        begin
            if (is_lower(c))
            begin
                append_en = 1'b1;
                mode_next = MODE_WORD;
            end
            else if (is_digit(c))
            begin
                append_en = 1'b1;
                mode_next = MODE_NUM;
            end
            else
            begin
                case (c) inside
                    CH_SPACE, CH_NEWLINE, CH_TAB: ;
                    CH_HASH:    mode_next = MODE_CMT;
                    CH_QUOTE:   mode_next = MODE_STR;
                    CH_AT:      mode_next = MODE_ATTR;
                    CH_LPAREN:  begin tail_en_next = 1'b1; tail_kind_next = KIND_LPAREN; end
                    CH_RPAREN:  begin tail_en_next = 1'b1; tail_kind_next = KIND_RPAREN; end
                    CH_LBRACE:  begin tail_en_next = 1'b1; tail_kind_next = KIND_LBRACE; end
                    CH_RBRACE:  begin tail_en_next = 1'b1; tail_kind_next = KIND_RBRACE; end
                    CH_SEMI:    begin tail_en_next = 1'b1; tail_kind_next = KIND_SEMI; end
                    CH_COLON:   begin tail_en_next = 1'b1; tail_kind_next = KIND_COLON; end
                    CH_EQUAL:   begin pend_next = OP_ASSIGN;  mode_next = MODE_OP; end
                    CH_LESS:    begin pend_next = OP_LESS;    mode_next = MODE_OP; end
                    CH_GREATER: begin pend_next = OP_GREATER; mode_next = MODE_OP; end
                    CH_BANG:    begin pend_next = OP_BANG;    mode_next = MODE_OP; end
                    default:
                    begin
                        tail_en_next   = 1'b1;
                        tail_kind_next = KIND_ERROR;
                        tail_byte_next = c;
                        tail_has_next  = 1'b1;
                    end
                endcase
            end
        end

        if (append_en)
        begin
            app_pos     = len_next;
            append_fits = app_pos < LEN_W'(MAX_WORD_BYTES);
            if (append_fits)
            begin
                mask_next = mask_next & kw_step(app_pos, c);
                len_next  = app_pos + LEN_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        text_mode = 1'b0;
        case (mode_reg) inside
            MODE_WORD, MODE_NUM, MODE_STR, MODE_ATTR: text_mode = 1'b1;
            default: text_mode = 1'b0;
        endcase

        fl_text_next   = flush_en && text_mode && (len_reg != '0)
                         && !((mode_reg == MODE_WORD) && kw_hit);
        fl_single_next = flush_en && !fl_text_next && (text_mode || (mode_reg == MODE_OP));
        fl_trunc_next  = text_mode && ovf_reg && !((mode_reg == MODE_WORD) && kw_hit);

        case (mode_reg)
            MODE_WORD: fl_kind_next = kw_hit ? kw_kind : KIND_IDENT;
            MODE_NUM:  fl_kind_next = KIND_NUMBER;
            MODE_STR:  fl_kind_next = KIND_STRING;
            MODE_ATTR: fl_kind_next = KIND_ATTR;
            MODE_OP:   fl_kind_next = KIND_OP_BASE + {2'b00, pend_reg, 1'b0};
            default:   fl_kind_next = KIND_ERROR;
        endcase

        acc_we     = accept && append_en && append_fits && !fl_text_next;
        dw_en_next = append_en && fl_text_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        src_ready      = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = app_pos[IDX_W-1:0];
        mem_wdata      = c;
        load           = 1'b0;
        out_next       = out_reg;
        idx_next       = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                src_ready = 1'b1;
                mem_we    = acc_we;
                if (accept)
                begin
                    idx_next = '0;
                    if (fl_text_next)
                        state_next = ST_READ;
                    else if (fl_single_next)
                        state_next = ST_SINGLE;
                    else if (tail_en_next)
                        state_next = ST_TAIL;
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (slot_free)
                begin
                    load     = 1'b1;
                    out_next = '{token_kind: fl_kind_reg, text_byte: mem_rdata_reg,
                                 has_text: 1'b1, text_truncated: fl_trunc_reg,
                                 token_done: is_end, last: is_end && !tail_en_reg};
                    if (is_end)
                    begin
                        mem_we     = dw_en_reg;
                        mem_waddr  = '0;
                        mem_wdata  = dw_byte_reg;
                        state_next = tail_en_reg ? ST_TAIL : ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_SINGLE:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    out_next   = '{token_kind: fl_kind_reg, text_byte: 8'h00,
                                   has_text: 1'b0, text_truncated: fl_trunc_reg,
                                   token_done: 1'b1, last: !tail_en_reg};
                    state_next = tail_en_reg ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    out_next   = '{token_kind: tail_kind_reg, text_byte: tail_byte_reg,
                                   has_text: tail_has_reg, text_truncated: 1'b0,
                                   token_done: 1'b1, last: 1'b1};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (tok_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_IDLE;
            pend_reg      <= OP_ASSIGN;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            mask_reg      <= '1;
            fl_text_reg   <= 1'b0;
            fl_single_reg <= 1'b0;
            tail_en_reg   <= 1'b0;
            dw_en_reg     <= 1'b0;
            flen_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                mode_reg      <= mode_next;
                pend_reg      <= pend_next;
                len_reg       <= len_next;
                ovf_reg       <= ovf_next;
                mask_reg      <= mask_next;
                fl_text_reg   <= fl_text_next;
                fl_single_reg <= fl_single_next;
                tail_en_reg   <= tail_en_next;
                dw_en_reg     <= dw_en_next;
                flen_reg      <= len_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
        if (accept)
        begin
            fl_kind_reg   <= fl_kind_next;
            fl_trunc_reg  <= fl_trunc_next;
            tail_kind_reg <= tail_kind_next;
            tail_byte_reg <= tail_byte_next;
            tail_has_reg  <= tail_has_next;
            dw_byte_reg   <= c;
        end
    end

    `ASSERT_ALWAYS(a_len_bound, len_reg <= LEN_W'(MAX_WORD_BYTES), "Word too long.")
    `ASSERT_ALWAYS(a_ovf_full, !ovf_reg || len_reg == LEN_W'(MAX_WORD_BYTES), "Early overflow.")
    `ASSERT_ALWAYS(a_port_conflict, !(mem_we && mem_re), "Memory read and write together.")
    `ASSERT_ALWAYS(a_send_range, state_reg != ST_SEND || fl_text_reg, "Readout without text.")
    `ASSERT_ALWAYS(a_single_src, state_reg != ST_SINGLE || fl_single_reg, "Single without flush.")
    `ASSERT_NEXT(a_last_idle, load && out_next.last, state_reg == ST_IDLE, "Busy after last.")

endmodule
